[hdl/trd_pkg.sv]
package trd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CRD_W   = 16;
    localparam int DEPTH_W = 32;
    localparam int PIX_W   = 10;
    localparam int DIM_W   = 11;
    localparam int BOX_W   = 10;

    // datapath widths
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int EDGE_W  = 35;
    localparam int MAG_W   = 34;
    localparam int HALF_W  = 17;
    localparam int PP_W    = HALF_W + DEPTH_W;
    localparam int VPROD_W = MAG_W + DEPTH_W;
    localparam int NUM_W   = 68;
    localparam int Q_W     = 32;
    localparam int REM_W   = NUM_W - Q_W;
    localparam int BOXS_W  = 14;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_PIXEL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] REG_DEPTH_ENABLE  = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;
    localparam logic [1:0] REG_CLEAR_DEPTH   = 2'd3;

    localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 11'd480;
    localparam logic [DEPTH_W-1:0] CLEAR_DEPTH_RST   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]               cmd;
        logic signed [CRD_W-1:0]  first_x;
        logic signed [CRD_W-1:0]  first_y;
        logic [DEPTH_W-1:0]       first_depth;
        logic signed [CRD_W-1:0]  second_x;
        logic signed [CRD_W-1:0]  second_y;
        logic [DEPTH_W-1:0]       second_depth;
        logic signed [CRD_W-1:0]  third_x;
        logic signed [CRD_W-1:0]  third_y;
        logic [DEPTH_W-1:0]       third_depth;
        logic [PIX_W-1:0]         pixel_x;
        logic [PIX_W-1:0]         pixel_y;
    } item_t;

    typedef struct packed {
        logic               degenerate;
        logic               box_empty;
        logic [BOX_W-1:0]   box_min_x;
        logic [BOX_W-1:0]   box_max_x;
        logic [BOX_W-1:0]   box_min_y;
        logic [BOX_W-1:0]   box_max_y;
        logic               covered;
        logic               draw;
        logic [DEPTH_W-1:0] pixel_depth;
    } result_t;

    typedef struct packed {
        logic [1:0]         index;
        logic [DEPTH_W-1:0] data;
    } cfg_t;

endpackage

[hdl/trd_chan_if.sv]
interface trd_chan_if #(
    parameter type word_t = logic
) ();
    logic  valid;
    logic  ready;
    word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

[hdl/triangle_raster_depth_test.sv]
// channel | dir | word                          | handshake
// item    | in  | trd_pkg::item_t (cmd, verts)  | valid/ready
// result  | out | trd_pkg::result_t             | valid/ready
// cfg     | in  | trd_pkg::cfg_t (index, data)  | valid/ready, always ready
//
// One word per cycle in and out while result is not stalled.
// Depth interpolation uses a 33-stage pipelined divider.
// Depth buffer is one memory, read one stage before write, with a forward path.
// Reset clears control and setup and sets config to defaults; depth memory is undefined until cleared.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module triangle_raster_depth_test #(
    parameter int MAX_WIDTH  = trd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = trd_pkg::MAX_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    trd_chan_if.sink    item,
    trd_chan_if.source  result,
    trd_chan_if.sink    cfg
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int QW    = trd_pkg::Q_W;
    localparam int DW    = trd_pkg::DEPTH_W;
    localparam int BW    = trd_pkg::BOXS_W;
    localparam int XW    = trd_pkg::BOX_W;
    localparam int FW    = trd_pkg::DIFF_W;
    localparam int MW    = trd_pkg::MAG_W;
    localparam int HFW   = trd_pkg::HALF_W;

    typedef struct packed {
        logic [1:0]    cmd;
        logic          onscreen;
        logic [AW-1:0] addr;
        logic          box_empty;
        logic [XW-1:0] bminx;
        logic [XW-1:0] bmaxx;
        logic [XW-1:0] bminy;
        logic [XW-1:0] bmaxy;
        logic          degenerate;
        logic          covered;
    } side_t;

    // configuration
    logic                   depth_enable_reg;
    logic [trd_pkg::DIM_W-1:0] screen_width_reg;
    logic [trd_pkg::DIM_W-1:0] screen_height_reg;
    logic [DW-1:0]          clear_depth_reg;
    logic [CW-1:0]          act_w;
    logic [HW-1:0]          act_h;

    // setup
    logic signed [trd_pkg::CRD_W-1:0] setup_x_reg [3];
    logic signed [trd_pkg::CRD_W-1:0] setup_y_reg [3];
    logic [DW-1:0]                    setup_depth_reg [3];

    logic adv;
    logic item_load;

    // stage 1
    logic        v1_reg;
    logic [1:0]  cmd1_reg;
    logic signed [trd_pkg::CRD_W-1:0] x1_reg [3];
    logic signed [trd_pkg::CRD_W-1:0] y1_reg [3];
    logic [DW-1:0]                    z1_reg [3];
    logic [trd_pkg::PIX_W-1:0]        px1_reg;
    logic [trd_pkg::PIX_W-1:0]        py1_reg;

    // stage 2
    logic        v2_reg;
    side_t       side2_next, side2_reg;
    logic signed [FW-1:0] dpx_next [4], dby_next [4], dpy_next [4], dbx_next [4];
    logic signed [FW-1:0] dpx_reg [4], dby_reg [4], dpy_reg [4], dbx_reg [4];
    logic signed [FW-1:0] pxs, pys;
    logic signed [BW-1:0] fx2_reg [3], cx2_reg [3], fy2_reg [3], cy2_reg [3];
    logic [DW-1:0]        z2_reg [3];

    // stage 3
    logic        v3_reg;
    side_t       side3_reg;
    logic signed [trd_pkg::PROD_W-1:0] pa3_reg [4], pb3_reg [4];
    logic signed [BW-1:0] minx_next, maxx_next, miny_next, maxy_next;
    logic signed [BW-1:0] minx3_reg, maxx3_reg, miny3_reg, maxy3_reg;
    logic signed [BW-1:0] wl, hl;
    logic [DW-1:0]        z3_reg [3];

    // stage 4
    logic        v4_reg;
    side_t       side4_next, side4_reg;
    logic signed [trd_pkg::EDGE_W-1:0] e4_reg [4];
    logic        empty4;
    logic [DW-1:0]        z4_reg [3];

    // stage 5
    logic        v5_reg;
    side_t       side5_next, side5_reg;
    logic        neg5, cov5, zero5;
    logic [MW-1:0] mag5_reg [3];
    logic [MW-1:0] amag5_reg;
    logic [DW-1:0] z5_reg [3];

    // stage 6
    logic        v6_reg;
    side_t       side6_reg;
    logic [trd_pkg::PP_W-1:0] pl6_reg [3], ph6_reg [3];
    logic [MW-1:0] amag6_reg;

    // stage 7
    logic        v7_reg;
    side_t       side7_reg;
    logic [trd_pkg::VPROD_W-1:0] vp7_reg [3];
    logic [MW-2:0] half7_reg;
    logic [MW-1:0] amag7_reg;
    logic [trd_pkg::NUM_W-1:0] div_num;

    // divider
    logic          dv_reg [QW+1];
    side_t         sided_reg [QW+1];
    logic [QW-1:0] quo;
    logic          sat;

    // memory stage
    logic          vm_reg;
    side_t         m_side_reg;
    logic [DW-1:0] m_z_reg;
    logic [DW-1:0] mem_q_reg;
    logic [DW-1:0] depth_mem [DEPTH];
    logic          fwd_we_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [DW-1:0] fwd_data_reg;
    logic [DW-1:0] m_old;
    logic          m_nearer, m_draw, m_we;
    logic [DW-1:0] m_wdata;
    trd_pkg::result_t result_next, result_reg;
    logic          out_valid_reg;

    assign adv          = !out_valid_reg || result.ready;
    assign item.ready   = adv;
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.word  = result_reg;
    assign item_load    = item.valid && adv && (item.word.cmd == trd_pkg::CMD_LOAD);

    always_comb
    begin
        if ({2'b00, screen_width_reg} < 13'(MAX_WIDTH))
            act_w = CW'(screen_width_reg);
        else
            act_w = CW'(MAX_WIDTH);
        if ({2'b00, screen_height_reg} < 13'(MAX_HEIGHT))
            act_h = HW'(screen_height_reg);
        else
            act_h = HW'(MAX_HEIGHT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_enable_reg  <= 1'b1;
            screen_width_reg  <= trd_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= trd_pkg::SCREEN_HEIGHT_RST;
            clear_depth_reg   <= trd_pkg::CLEAR_DEPTH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.word.index)
                trd_pkg::REG_DEPTH_ENABLE:  depth_enable_reg  <= cfg.word.data[0];
                trd_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.word.data[10:0];
                trd_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg.word.data[10:0];
                trd_pkg::REG_CLEAR_DEPTH:   clear_depth_reg   <= cfg.word.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                setup_x_reg[i]     <= '0;
                setup_y_reg[i]     <= '0;
                setup_depth_reg[i] <= '0;
            end
        end
        else if (item_load)
        begin
            setup_x_reg[0]     <= item.word.first_x;
            setup_y_reg[0]     <= item.word.first_y;
            setup_depth_reg[0] <= item.word.first_depth;
            setup_x_reg[1]     <= item.word.second_x;
            setup_y_reg[1]     <= item.word.second_y;
            setup_depth_reg[1] <= item.word.second_depth;
            setup_x_reg[2]     <= item.word.third_x;
            setup_y_reg[2]     <= item.word.third_y;
            setup_depth_reg[2] <= item.word.third_depth;
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            for (int k = 0; k <= QW; k++)
                dv_reg[k] <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_we_reg    <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            dv_reg[0] <= v7_reg;
            for (int k = 0; k < QW; k++)
                dv_reg[k+1] <= dv_reg[k];
            vm_reg        <= dv_reg[QW];
            out_valid_reg <= vm_reg;
            fwd_we_reg    <= m_we;
        end
    end

    // stage 2 logic: lane differences, box rounding, address
    always_comb
    begin
        pxs = $signed({3'b000, px1_reg, 4'b1000});
        pys = $signed({3'b000, py1_reg, 4'b1000});
        for (int i = 0; i < 3; i++)
        begin
            dpx_next[i] = pxs - FW'(x1_reg[(i+1)%3]);
            dpy_next[i] = pys - FW'(y1_reg[(i+1)%3]);
            dbx_next[i] = FW'(x1_reg[(i+2)%3]) - FW'(x1_reg[(i+1)%3]);
            dby_next[i] = FW'(y1_reg[(i+2)%3]) - FW'(y1_reg[(i+1)%3]);
        end
        // signed area lane
        dpx_next[3] = FW'(x1_reg[2]) - FW'(x1_reg[0]);
        dpy_next[3] = FW'(y1_reg[2]) - FW'(y1_reg[0]);
        dbx_next[3] = FW'(x1_reg[1]) - FW'(x1_reg[0]);
        dby_next[3] = FW'(y1_reg[1]) - FW'(y1_reg[0]);

        side2_next            = '0;
        side2_next.cmd        = cmd1_reg;
        side2_next.onscreen   = ({3'b000, px1_reg} < 13'(act_w)) &&
                                ({3'b000, py1_reg} < 13'(act_h));
        side2_next.addr       = AW'(py1_reg) * AW'(act_w) + AW'(px1_reg);
    end

    // stage 3 logic: box min/max and clip
    always_comb
    begin
        wl = $signed(BW'(act_w));
        hl = $signed(BW'(act_h));
        minx_next = fx2_reg[0];
        maxx_next = cx2_reg[0];
        miny_next = fy2_reg[0];
        maxy_next = cy2_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (fx2_reg[i] < minx_next)
                minx_next = fx2_reg[i];
            if (cx2_reg[i] > maxx_next)
                maxx_next = cx2_reg[i];
            if (fy2_reg[i] < miny_next)
                miny_next = fy2_reg[i];
            if (cy2_reg[i] > maxy_next)
                maxy_next = cy2_reg[i];
        end
        if (minx_next < 0)
            minx_next = '0;
        if (miny_next < 0)
            miny_next = '0;
        if (maxx_next >= wl)
            maxx_next = wl - BW'(1);
        if (maxy_next >= hl)
            maxy_next = hl - BW'(1);
    end

    // stage 4 logic: empty box
    always_comb
    begin
        empty4     = (minx3_reg > maxx3_reg) || (miny3_reg > maxy3_reg);
        side4_next = side3_reg;
        side4_next.box_empty = empty4;
        side4_next.bminx = empty4 ? '0 : XW'(minx3_reg);
        side4_next.bmaxx = empty4 ? '0 : XW'(maxx3_reg);
        side4_next.bminy = empty4 ? '0 : XW'(miny3_reg);
        side4_next.bmaxy = empty4 ? '0 : XW'(maxy3_reg);
    end

    // stage 5 logic: inside test with either winding, degenerate flag
    always_comb
    begin
        neg5  = e4_reg[3] < 0;
        zero5 = e4_reg[3] == 0;
        cov5  = (side4_reg.cmd == trd_pkg::CMD_PIXEL) && !zero5;
        for (int i = 0; i < 3; i++)
        begin
            if (e4_reg[i] != 0 && ((e4_reg[i] < 0) != neg5))
                cov5 = 1'b0;
        end
        side5_next = side4_reg;
        side5_next.covered = cov5;
        if (side4_reg.cmd != trd_pkg::CMD_LOAD)
        begin
            side5_next.degenerate = 1'b0;
            side5_next.box_empty  = 1'b0;
            side5_next.bminx      = '0;
            side5_next.bmaxx      = '0;
            side5_next.bminy      = '0;
            side5_next.bmaxy      = '0;
        end
        else if (zero5)
        begin
            side5_next.degenerate = 1'b1;
            side5_next.box_empty  = 1'b1;
            side5_next.bminx      = '0;
            side5_next.bmaxx      = '0;
            side5_next.bminy      = '0;
            side5_next.bmaxy      = '0;
        end
        else
        begin
            side5_next.degenerate = 1'b0;
        end
    end

    assign div_num = trd_pkg::NUM_W'(vp7_reg[0]) + trd_pkg::NUM_W'(vp7_reg[1])
                   + trd_pkg::NUM_W'(vp7_reg[2]) + trd_pkg::NUM_W'(half7_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd1_reg <= item.word.cmd;
            px1_reg  <= item.word.pixel_x;
            py1_reg  <= item.word.pixel_y;
            if (item.word.cmd == trd_pkg::CMD_LOAD)
            begin
                x1_reg[0] <= item.word.first_x;
                y1_reg[0] <= item.word.first_y;
                z1_reg[0] <= item.word.first_depth;
                x1_reg[1] <= item.word.second_x;
                y1_reg[1] <= item.word.second_y;
                z1_reg[1] <= item.word.second_depth;
                x1_reg[2] <= item.word.third_x;
                y1_reg[2] <= item.word.third_y;
                z1_reg[2] <= item.word.third_depth;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x1_reg[i] <= setup_x_reg[i];
                    y1_reg[i] <= setup_y_reg[i];
                    z1_reg[i] <= setup_depth_reg[i];
                end
            end

            side2_reg <= side2_next;
            for (int i = 0; i < 4; i++)
            begin
                dpx_reg[i] <= dpx_next[i];
                dpy_reg[i] <= dpy_next[i];
                dbx_reg[i] <= dbx_next[i];
                dby_reg[i] <= dby_next[i];
            end
            for (int i = 0; i < 3; i++)
            begin
                fx2_reg[i] <= BW'(x1_reg[i] >>> 4);
                fy2_reg[i] <= BW'(y1_reg[i] >>> 4);
                cx2_reg[i] <= BW'((FW'(x1_reg[i]) + 17'sd15) >>> 4);
                cy2_reg[i] <= BW'((FW'(y1_reg[i]) + 17'sd15) >>> 4);
                z2_reg[i]  <= z1_reg[i];
            end

            side3_reg <= side2_reg;
            for (int i = 0; i < 4; i++)
            begin
                pa3_reg[i] <= dpx_reg[i] * dby_reg[i];
                pb3_reg[i] <= dpy_reg[i] * dbx_reg[i];
            end
            minx3_reg <= minx_next;
            maxx3_reg <= maxx_next;
            miny3_reg <= miny_next;
            maxy3_reg <= maxy_next;
            for (int i = 0; i < 3; i++)
                z3_reg[i] <= z2_reg[i];

            side4_reg <= side4_next;
            for (int i = 0; i < 4; i++)
                e4_reg[i] <= trd_pkg::EDGE_W'(pa3_reg[i]) - trd_pkg::EDGE_W'(pb3_reg[i]);
            for (int i = 0; i < 3; i++)
                z4_reg[i] <= z3_reg[i];

            side5_reg <= side5_next;
            for (int i = 0; i < 3; i++)
            begin
                mag5_reg[i] <= (e4_reg[i] < 0) ? MW'(-e4_reg[i]) : MW'(e4_reg[i]);
                z5_reg[i]   <= z4_reg[i];
            end
            amag5_reg <= neg5 ? MW'(-e4_reg[3]) : MW'(e4_reg[3]);

            side6_reg <= side5_reg;
            for (int i = 0; i < 3; i++)
            begin
                pl6_reg[i] <= HFW'(mag5_reg[i][HFW-1:0]) * trd_pkg::PP_W'(z5_reg[i]);
                ph6_reg[i] <= HFW'(mag5_reg[i][MW-1:HFW]) * trd_pkg::PP_W'(z5_reg[i]);
            end
            amag6_reg <= amag5_reg;

            side7_reg <= side6_reg;
            for (int i = 0; i < 3; i++)
                vp7_reg[i] <= {ph6_reg[i], {HFW{1'b0}}} + trd_pkg::VPROD_W'(pl6_reg[i]);
            half7_reg <= amag6_reg[MW-1:1];
            amag7_reg <= amag6_reg;

            sided_reg[0] <= side7_reg;
            for (int k = 0; k < QW; k++)
                sided_reg[k+1] <= sided_reg[k];

            m_side_reg <= sided_reg[QW];
            m_z_reg    <= sat ? {DW{1'b1}} : quo;

            fwd_addr_reg <= m_side_reg.addr;
            fwd_data_reg <= m_wdata;
            result_reg   <= result_next;
        end
    end

    trd_div u_div (
        .clk (clk),
        .en  (adv),
        .num (div_num),
        .den (amag7_reg),
        .quo (quo),
        .sat (sat)
    );

    // depth test, store and clear
    always_comb
    begin
        m_old    = (fwd_we_reg && fwd_addr_reg == m_side_reg.addr) ? fwd_data_reg : mem_q_reg;
        m_nearer = m_z_reg < m_old;
        m_draw   = m_side_reg.covered && m_side_reg.onscreen &&
                   (!depth_enable_reg || m_nearer);
        if (m_side_reg.cmd == trd_pkg::CMD_CLEAR)
        begin
            m_we    = vm_reg && m_side_reg.onscreen;
            m_wdata = clear_depth_reg;
        end
        else
        begin
            m_we    = vm_reg && m_side_reg.covered && m_side_reg.onscreen &&
                      depth_enable_reg && m_nearer;
            m_wdata = m_z_reg;
        end

        result_next             = '0;
        result_next.degenerate  = m_side_reg.degenerate;
        result_next.box_empty   = m_side_reg.box_empty;
        result_next.box_min_x   = m_side_reg.bminx;
        result_next.box_max_x   = m_side_reg.bmaxx;
        result_next.box_min_y   = m_side_reg.bminy;
        result_next.box_max_y   = m_side_reg.bmaxy;
        result_next.covered     = m_side_reg.covered;
        result_next.draw        = m_draw;
        result_next.pixel_depth = m_side_reg.covered ? m_z_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mem_q_reg <= depth_mem[sided_reg[QW].addr];
            if (m_we)
                depth_mem[m_side_reg.addr] <= m_wdata;
        end
    end
endmodule

[hdl/trd_div.sv]
module trd_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [trd_pkg::NUM_W-1:0]   num,
    input  logic [trd_pkg::MAG_W-1:0]   den,
    output logic [trd_pkg::Q_W-1:0]     quo,
    output logic                        sat
);
    localparam int QW = trd_pkg::Q_W;
    localparam int RW = trd_pkg::REM_W;
    localparam int NW = trd_pkg::NUM_W;

    logic [RW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [RW-1:0] den_reg [QW+1];
    logic          sat_reg [QW+1];

    logic [RW-1:0] rem_next [QW];
    logic [QW-1:0] low_next [QW];

    // one quotient bit per stage; low word shifts dividend bits out, quotient bits in
    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            rem_next[k] = {rem_reg[k][RW-2:0], low_reg[k][QW-1]};
            if (rem_next[k] >= den_reg[k])
            begin
                rem_next[k] = rem_next[k] - den_reg[k];
                low_next[k] = {low_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                low_next[k] = {low_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NW-1:QW];
            low_reg[0] <= num[QW-1:0];
            den_reg[0] <= RW'(den);
            sat_reg[0] <= (num[NW-1:QW] >= RW'(den));
            for (int k = 0; k < QW; k++)
            begin
                rem_reg[k+1] <= rem_next[k];
                low_reg[k+1] <= low_next[k];
                den_reg[k+1] <= den_reg[k];
                sat_reg[k+1] <= sat_reg[k];
            end
        end
    end

    assign quo = low_reg[QW];
    assign sat = sat_reg[QW];
endmodule
